>>> rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, sizes and codes for the dependency-graph pass counter.
// ----------------------------------------------------------------------------
package tsp_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_EDGES = 4096;
  localparam int NODE_AW   = $clog2(MAX_NODES);   // node index
  localparam int EDGE_AW   = $clog2(MAX_EDGES);   // edge index
  localparam int LINK_W    = EDGE_AW + 1;         // edge index plus empty flag
  localparam int CNT_W     = 11;                  // node count / positions
  localparam int LVL_W     = 11;                  // level
  localparam int PEND_W    = EDGE_AW + 1;         // in-degree

  localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(MAX_EDGES);

  // operation codes of an input word
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_EDGE  = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] node_count;
    logic [10:0] prerequisite_node;
    logic [10:0] dependent_node;
  } in_t;

  typedef struct packed {
    logic        has_cycle;
    logic [10:0] pass_count;
    logic        edge_overflow;
  } out_t;

  // datapath commands
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_SET_OVF,
    CMD_CLR_HEAD,
    CMD_EDGE_RD,
    CMD_EDGE_WR,
    CMD_SOL_CLR,
    CMD_CNT_RD,
    CMD_CNT_PR,
    CMD_CNT_WR,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_POP,
    CMD_POP_W,
    CMD_HEAD,
    CMD_E_RD,
    CMD_E_D,
    CMD_E_UP,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic       nodes_zero;
    logic       idx_last;
    logic       edges_zero;
    logic       eidx_last;
    logic       queue_empty;
    logic       head_empty;
    logic       link_empty;
    logic       edge_valid;
    logic       edge_full;
  } status_t;

endpackage

>>> rtl/tsp_ram.sv
// ----------------------------------------------------------------------------
// tsp_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tsp_ctrl.sv
// ----------------------------------------------------------------------------
// tsp_ctrl
// Sequencer: decodes each word and steps the datapath through loading,
// in-degree counting, the initial scan and the Kahn walk.
// ----------------------------------------------------------------------------
module tsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tsp_pkg::status_t status,
  output tsp_pkg::cmd_t    cmd,
  output logic             busy
);
  import tsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_OVF, ST_CLR_HEAD, ST_EDGE_RD, ST_EDGE_WR,
    ST_SOL_CLR, ST_CNT_RD, ST_CNT_PR, ST_CNT_WR, ST_SCAN_RD, ST_SCAN_CHK,
    ST_POP, ST_POP_W, ST_HEAD, ST_E_RD, ST_E_D, ST_E_UP, ST_DONE
  } state_t;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        case (status.item_op)
          OP_BEGIN: state_next = status.nodes_zero ? ST_IDLE : ST_CLR_HEAD;
          OP_EDGE: begin
            if (!status.edge_valid)    state_next = ST_IDLE;
            else if (status.edge_full) state_next = ST_OVF;
            else                       state_next = ST_EDGE_RD;
          end
          OP_SOLVE: state_next = status.nodes_zero ? ST_DONE : ST_SOL_CLR;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_OVF:      state_next = ST_IDLE;
      ST_CLR_HEAD: if (status.idx_last) state_next = ST_IDLE;
      ST_EDGE_RD:  state_next = ST_EDGE_WR;
      ST_EDGE_WR:  state_next = ST_IDLE;
      ST_SOL_CLR: begin
        if (status.idx_last) state_next = status.edges_zero ? ST_SCAN_RD : ST_CNT_RD;
      end
      ST_CNT_RD:   state_next = ST_CNT_PR;
      ST_CNT_PR:   state_next = ST_CNT_WR;
      ST_CNT_WR:   state_next = status.eidx_last ? ST_SCAN_RD : ST_CNT_RD;
      ST_SCAN_RD:  state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: state_next = status.idx_last ? ST_POP : ST_SCAN_RD;
      ST_POP:      state_next = status.queue_empty ? ST_DONE : ST_POP_W;
      ST_POP_W:    state_next = ST_HEAD;
      ST_HEAD:     state_next = status.head_empty ? ST_POP : ST_E_RD;
      ST_E_RD:     state_next = ST_E_D;
      ST_E_D:      state_next = ST_E_UP;
      ST_E_UP:     state_next = status.link_empty ? ST_POP : ST_E_RD;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

  // command decode
  always_comb begin
    case (state)
      ST_IDLE:     cmd = start ? CMD_LOAD : CMD_NOP;
      ST_OVF:      cmd = CMD_SET_OVF;
      ST_CLR_HEAD: cmd = CMD_CLR_HEAD;
      ST_EDGE_RD:  cmd = CMD_EDGE_RD;
      ST_EDGE_WR:  cmd = CMD_EDGE_WR;
      ST_SOL_CLR:  cmd = CMD_SOL_CLR;
      ST_CNT_RD:   cmd = CMD_CNT_RD;
      ST_CNT_PR:   cmd = CMD_CNT_PR;
      ST_CNT_WR:   cmd = CMD_CNT_WR;
      ST_SCAN_RD:  cmd = CMD_SCAN_RD;
      ST_SCAN_CHK: cmd = CMD_SCAN_CHK;
      ST_POP:      cmd = CMD_POP;
      ST_POP_W:    cmd = CMD_POP_W;
      ST_HEAD:     cmd = CMD_HEAD;
      ST_E_RD:     cmd = CMD_E_RD;
      ST_E_D:      cmd = CMD_E_D;
      ST_E_UP:     cmd = CMD_E_UP;
      ST_DONE:     cmd = CMD_DONE;
      default:     cmd = CMD_NOP;
    endcase
  end

  // busy tracks the sequencer leaving idle
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE)) else $error("busy out of step with state");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted word did not set busy");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LOAD) |-> (state == ST_IDLE)) else $error("load outside idle");

endmodule

>>> rtl/tsp_dp.sv
// ----------------------------------------------------------------------------
// tsp_dp
// Datapath: edge store, list heads, in-degrees, levels, ready queue and
// the counters that walk them, driven one command per cycle.
// ----------------------------------------------------------------------------
module tsp_dp (
  input  logic             clk,
  input  logic             rst,
  input  tsp_pkg::cmd_t    cmd,
  input  tsp_pkg::in_t     item,
  output tsp_pkg::status_t status,
  output logic             done,
  output tsp_pkg::out_t    result
);
  import tsp_pkg::*;

  // control registers
  logic [1:0]         item_op;
  logic [CNT_W-1:0]   nodes;
  logic [PEND_W-1:0]  edges;
  logic               overflow;
  logic [NODE_AW-1:0] idx;
  logic [EDGE_AW-1:0] eidx;
  logic [CNT_W-1:0]   rpos, wpos;
  logic [LVL_W-1:0]   best;

  // payload registers
  logic [10:0]        pre, dep;
  logic [NODE_AW-1:0] x_reg, d_reg;
  logic [LVL_W-1:0]   lx;
  logic [LINK_W-1:0]  e_reg;

  // memory ports
  logic               head_we, tgt_we, pend_we, lvl_we, q_we;
  logic [NODE_AW-1:0] head_wa, head_ra, pend_wa, pend_ra, lvl_wa, lvl_ra, q_wa, q_ra;
  logic [EDGE_AW-1:0] tgt_wa, tgt_ra;
  logic [LINK_W-1:0]  head_wd, head_q, link_q;
  logic [NODE_AW-1:0] tgt_q, q_q;
  logic [PEND_W-1:0]  pend_wd, pend_q, pend_dec;
  logic [LVL_W-1:0]   lvl_wd, lvl_q, cand;
  logic [NODE_AW-1:0] pre_i, dep_i;
  logic [CNT_W-1:0]   nodes_sat;
  logic               push_ok;

  tsp_ram #(.WIDTH(LINK_W),  .DEPTH(MAX_NODES)) u_head (.clk, .we(head_we),
    .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_q));
  tsp_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_EDGES)) u_tgt (.clk, .we(tgt_we),
    .waddr(tgt_wa), .wdata(dep_i), .raddr(tgt_ra), .rdata(tgt_q));
  tsp_ram #(.WIDTH(LINK_W),  .DEPTH(MAX_EDGES)) u_link (.clk, .we(tgt_we),
    .waddr(tgt_wa), .wdata(head_q), .raddr(tgt_ra), .rdata(link_q));
  tsp_ram #(.WIDTH(PEND_W),  .DEPTH(MAX_NODES)) u_pend (.clk, .we(pend_we),
    .waddr(pend_wa), .wdata(pend_wd), .raddr(pend_ra), .rdata(pend_q));
  tsp_ram #(.WIDTH(LVL_W),   .DEPTH(MAX_NODES)) u_lvl (.clk, .we(lvl_we),
    .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_q));
  tsp_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_q (.clk, .we(q_we),
    .waddr(q_wa), .wdata((cmd == CMD_E_UP) ? d_reg : idx),
    .raddr(q_ra), .rdata(q_q));

  assign pre_i     = NODE_AW'(pre - 11'd1);
  assign dep_i     = NODE_AW'(dep - 11'd1);
  assign nodes_sat = (item.node_count[10] && (|item.node_count[9:0]))
                     ? CNT_W'(MAX_NODES) : item.node_count;
  assign cand      = (d_reg > x_reg) ? lx : LVL_W'(lx + 1'b1);
  assign pend_dec  = PEND_W'(pend_q - 1'b1);
  assign push_ok   = (pend_dec == '0) && (wpos < CNT_W'(MAX_NODES));

  // status to the sequencer
  always_comb begin
    status.item_op     = item_op;
    status.nodes_zero  = (nodes == '0);
    status.idx_last    = ({1'b0, idx} == CNT_W'(nodes - 1'b1));
    status.edges_zero  = (edges == '0);
    status.eidx_last   = ({1'b0, eidx} == PEND_W'(edges - 1'b1));
    status.queue_empty = (rpos == wpos);
    status.head_empty  = head_q[LINK_W-1];
    status.link_empty  = e_reg[LINK_W-1];
    status.edge_valid  = (pre != '0) && (pre <= nodes) && (dep != '0) && (dep <= nodes);
    status.edge_full   = edges[PEND_W-1];
  end

  // memory port steering
  always_comb begin
    head_we = 1'b0; head_wa = idx;   head_wd = LINK_EMPTY; head_ra = pre_i;
    tgt_we  = 1'b0; tgt_wa  = edges[EDGE_AW-1:0];         tgt_ra  = eidx;
    pend_we = 1'b0; pend_wa = idx;   pend_wd = '0;         pend_ra = tgt_q;
    lvl_we  = 1'b0; lvl_wa  = idx;   lvl_wd  = '0;         lvl_ra  = tgt_q;
    q_we    = 1'b0; q_wa    = wpos[NODE_AW-1:0];           q_ra    = rpos[NODE_AW-1:0];
    case (cmd)
      CMD_CLR_HEAD: head_we = 1'b1;
      CMD_EDGE_WR: begin
        tgt_we  = 1'b1;
        head_we = 1'b1;
        head_wa = pre_i;
        head_wd = edges;
      end
      CMD_SOL_CLR: begin
        pend_we = 1'b1;
        lvl_we  = 1'b1;
      end
      CMD_CNT_WR: begin
        pend_we = 1'b1;
        pend_wa = d_reg;
        pend_wd = PEND_W'(pend_q + 1'b1);
      end
      CMD_SCAN_RD: pend_ra = idx;
      CMD_SCAN_CHK: begin
        if (pend_q == '0) begin
          q_we   = 1'b1;
          lvl_we = 1'b1;
          lvl_wd = LVL_W'(1);
        end
      end
      CMD_POP_W: begin
        head_ra = q_q;
        lvl_ra  = q_q;
      end
      CMD_E_RD: tgt_ra = e_reg[EDGE_AW-1:0];
      CMD_E_UP: begin
        pend_we = 1'b1;
        pend_wa = d_reg;
        pend_wd = pend_dec;
        lvl_wa  = d_reg;
        lvl_wd  = cand;
        lvl_we  = (cand > lvl_q);
        q_we    = push_ok;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      item_op  <= OP_BEGIN;
      nodes    <= '0;
      edges    <= '0;
      overflow <= 1'b0;
      idx      <= '0;
      eidx     <= '0;
      rpos     <= '0;
      wpos     <= '0;
      best     <= '0;
      done     <= 1'b0;
    end else begin
      done <= (cmd == CMD_DONE);
      case (cmd)
        CMD_LOAD: begin
          item_op <= item.operation;
          idx     <= '0;
          eidx    <= '0;
          if (item.operation == OP_BEGIN) begin
            nodes    <= nodes_sat;
            edges    <= '0;
            overflow <= 1'b0;
          end
          if (item.operation == OP_SOLVE) begin
            rpos <= '0;
            wpos <= '0;
            best <= '0;
          end
        end
        CMD_SET_OVF:  overflow <= 1'b1;
        CMD_EDGE_WR:  edges <= PEND_W'(edges + 1'b1);
        CMD_CLR_HEAD, CMD_SOL_CLR, CMD_SCAN_CHK: begin
          idx <= status.idx_last ? '0 : NODE_AW'(idx + 1'b1);
          if (cmd == CMD_SCAN_CHK && pend_q == '0) begin
            wpos <= CNT_W'(wpos + 1'b1);
            if (best == '0) best <= LVL_W'(1);
          end
        end
        CMD_CNT_WR:   eidx <= status.eidx_last ? '0 : EDGE_AW'(eidx + 1'b1);
        CMD_POP:      if (!status.queue_empty) rpos <= CNT_W'(rpos + 1'b1);
        CMD_E_UP: begin
          if (push_ok) wpos <= CNT_W'(wpos + 1'b1);
          if (cand > lvl_q && cand > best) best <= cand;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        pre <= item.prerequisite_node;
        dep <= item.dependent_node;
      end
      CMD_CNT_PR: d_reg <= tgt_q;
      CMD_POP_W:  x_reg <= q_q;
      CMD_HEAD: begin
        lx    <= lvl_q;
        e_reg <= head_q;
      end
      CMD_E_D: begin
        d_reg <= tgt_q;
        e_reg <= link_q;
      end
      CMD_DONE: begin
        result.has_cycle     <= (wpos != nodes);
        result.pass_count    <= (wpos != nodes) ? '0 : best;
        result.edge_overflow <= overflow;
      end
      default: ;
    endcase
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    rpos <= wpos) else $error("ready queue read passed write");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edges <= PEND_W'(MAX_EDGES)) else $error("edge count above capacity");

endmodule

>>> rtl/topo_sort_ordered_pass_count.sv
// ----------------------------------------------------------------------------
// topo_sort_ordered_pass_count
// Dependency-graph pass counter: loads edges, then runs a Kahn sort.
// ----------------------------------------------------------------------------
// Begin word: sweeps the list heads. Edge word: checks the edge, then drops it,
// stores it or sets the overflow flag. Solve word: runs the clear, count, scan
// and walk loops, paced by the single read port of each RAM.
// One word at a time; after a solve word the result strobe (done) rises at the edge busy falls,
// and the receiver cannot stall it.
// Synchronous reset empties the graph; no memory sweep after reset.
module topo_sort_ordered_pass_count (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  tsp_pkg::in_t  item,
  output logic          busy,
  output logic          done,
  output tsp_pkg::out_t result
);
  import tsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsp_ctrl u_ctrl (
    .clk, .rst, .start, .status, .cmd, .busy
  );

  tsp_dp u_dp (
    .clk, .rst, .cmd, .item, .status, .done, .result
  );

endmodule
